@@ hw/rtl/fwt_pkg.sv @@
// ----------------------------------------------------------------------------
// fwt_pkg
// Shared types, codes and widths for the futex waiter table.
// ----------------------------------------------------------------------------
package fwt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int CMD_W   = 3;
	localparam int ADDR_W  = 64;
	localparam int WORD_W  = 32;
	localparam int WCNT_W  = 8;
	localparam int SIDX_W  = 6;
	localparam int STAT_W  = 2;
	localparam int VAL_W   = 7;

	localparam int IN_BITS  = CMD_W + ADDR_W + 2 * WORD_W + WCNT_W + SIDX_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STAT_W + VAL_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [1:0] ALIGN_MASK = 2'h3;

	localparam logic [CMD_W-1:0] CMD_PARK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WAKE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVAL = 2'd1;
	localparam logic [STAT_W-1:0] ST_AGAIN = 2'd2;

	typedef struct packed {
		logic capture;
		logic clr_scan;
		logic issue;
		logic commit;
	} fwt_cmd_t;

	typedef struct packed {
		logic needs_scan;
		logic last_issue;
		logic out_free;
	} fwt_stat_t;

endpackage

@@ hw/rtl/fwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// fwt_ctrl
// Sequencer: takes a request, runs the slot walk when needed, commits.
// ----------------------------------------------------------------------------
module fwt_ctrl
	import fwt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  fwt_stat_t stat,
	output fwt_cmd_t  ctrl
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		ctrl.capture  = 1'b0;
		ctrl.clr_scan = 1'b0;
		ctrl.issue    = 1'b0;
		ctrl.commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.capture = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.needs_scan) begin
					ctrl.clr_scan = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				ctrl.issue = 1'b1;
				if (stat.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctrl.commit = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/fwt_datapath.sv @@
// ----------------------------------------------------------------------------
// fwt_datapath
// Request registers, slot flags, address memory, walk logic and result.
// ----------------------------------------------------------------------------
module fwt_datapath
	import fwt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  in_data,
	input  fwt_cmd_t         ctrl,
	output fwt_stat_t        stat,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] expv_q;
	logic [WORD_W-1:0] curw_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic [SIDX_W-1:0] sidx_q;

	logic [SLOTS-1:0]  in_use_q;
	logic [SLOTS-1:0]  woken_q;
	logic [ADDR_W-1:0] addr_mem [SLOTS];

	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_s1;
	logic              v_s1;
	logic [ADDR_W-1:0] rd_s1;

	logic              found_q;
	logic [IDX_W-1:0]  slot_q;
	logic [VAL_W-1:0]  cnt_q;

	logic              m_valid_q;
	logic [STAT_W-1:0] m_stat_q;
	logic [VAL_W-1:0]  m_val_q;

	logic              addr_null;
	logic              park_bad;
	logic              mismatch;
	logic              sidx_ok;
	logic [IDX_W-1:0]  sidx_sel;
	logic              hit;
	logic              wake_all;
	logic [VAL_W-1:0]  limit;
	logic              wake_hit;
	logic [STAT_W-1:0] res_stat;
	logic [VAL_W-1:0]  res_val;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= in_data[CMD_W-1:0];
			addr_q <= in_data[CMD_W +: ADDR_W];
			expv_q <= in_data[CMD_W + ADDR_W +: WORD_W];
			curw_q <= in_data[CMD_W + ADDR_W + WORD_W +: WORD_W];
			wcnt_q <= in_data[CMD_W + ADDR_W + 2 * WORD_W +: WCNT_W];
			sidx_q <= in_data[CMD_W + ADDR_W + 2 * WORD_W + WCNT_W +: SIDX_W];
		end
	end

	assign addr_null = (addr_q == '0);
	assign park_bad  = addr_null || ((addr_q[1:0] & ALIGN_MASK) != 2'b00);
	assign mismatch  = (curw_q != expv_q);
	assign sidx_ok   = ({1'b0, sidx_q} < 7'(SLOTS));
	assign sidx_sel  = sidx_q[IDX_W-1:0];
	assign hit       = in_use_q[idx_s1] && (rd_s1 == addr_q);
	assign wake_all  = wcnt_q[WCNT_W-1];
	assign limit     = wcnt_q[VAL_W-1:0];
	assign wake_hit  = v_s1 && (cmd_q == CMD_WAKE) && hit && !woken_q[idx_s1]
		&& (wake_all || (cnt_q < limit));

	always_comb begin
		stat.last_issue = (idx_q == IDX_W'(SLOTS - 1));
		stat.out_free   = !m_valid_q || m_tready;
		case (cmd_q)
			CMD_PARK:  stat.needs_scan = !park_bad && !mismatch;
			CMD_WAKE:  stat.needs_scan = !addr_null && (wcnt_q != '0);
			CMD_COUNT: stat.needs_scan = 1'b1;
			default:   stat.needs_scan = 1'b0;
		endcase
	end

	// Slot walk: one memory read issued per cycle, evaluated in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			if (ctrl.clr_scan) begin
				idx_q <= '0;
			end else if (ctrl.issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_s1  <= addr_mem[idx_q];
		idx_s1 <= idx_q;
		if (ctrl.commit && (cmd_q == CMD_PARK) && !park_bad && !mismatch && found_q) begin
			addr_mem[slot_q] <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr_scan) begin
			found_q <= 1'b0;
			slot_q  <= '0;
			cnt_q   <= '0;
		end else if (v_s1) begin
			case (cmd_q)
				CMD_PARK: begin
					if (!found_q && !in_use_q[idx_s1]) begin
						found_q <= 1'b1;
						slot_q  <= idx_s1;
					end
				end
				CMD_WAKE: begin
					if (wake_hit) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				CMD_COUNT: begin
					if (hit) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			woken_q  <= '0;
		end else begin
			if (wake_hit) begin
				woken_q[idx_s1] <= 1'b1;
			end
			if (ctrl.commit) begin
				case (cmd_q)
					CMD_PARK: begin
						if (!park_bad && !mismatch && found_q) begin
							in_use_q[slot_q] <= 1'b1;
							woken_q[slot_q]  <= 1'b0;
						end
					end
					CMD_RELEASE: begin
						if (sidx_ok) begin
							in_use_q[sidx_sel] <= 1'b0;
							woken_q[sidx_sel]  <= 1'b0;
						end
					end
					CMD_CLEAR: begin
						in_use_q <= '0;
						woken_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		res_stat = ST_OK;
		res_val  = '0;
		case (cmd_q)
			CMD_PARK: begin
				if (park_bad) begin
					res_stat = ST_INVAL;
				end else if (mismatch || !found_q) begin
					res_stat = ST_AGAIN;
				end else begin
					res_val = VAL_W'(slot_q);
				end
			end
			CMD_WAKE: begin
				if (addr_null) begin
					res_stat = ST_INVAL;
				end else if (wcnt_q != '0) begin
					res_val = cnt_q;
				end
			end
			CMD_RELEASE: begin
			end
			CMD_COUNT: begin
				res_val = cnt_q;
			end
			CMD_QUERY: begin
				if (sidx_ok) begin
					res_val = VAL_W'(woken_q[sidx_sel]);
				end else begin
					res_stat = ST_INVAL;
				end
			end
			CMD_CLEAR: begin
			end
			default: begin
				res_stat = ST_INVAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			m_stat_q <= res_stat;
			m_val_q  <= res_val;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, m_val_q, m_stat_q};

endmodule

@@ hw/rtl/futex_waiter_table.sv @@
// ----------------------------------------------------------------------------
// futex_waiter_table
// Table of futex waiter slots: park, wake, release, count, query and clear.
// ----------------------------------------------------------------------------
//  Channel   Dir  Width  Contents (lowest bit first)
//  s_*       in   152    cmd, address, expected_value, current_word,
//                        wake_count, slot_index, zero fill
//  m_*       out  16     status, result_value, zero fill
//
// Park, wake and count walk the address memory one slot per cycle through its
// single read port, going from decode through scan and drain to done; release,
// query, clear, rejected requests and wakes with a zero wake_count skip the walk.
// Reset empties the table at once. A result waiting on m_tready does not
// stop the next request from being accepted; only its commit waits.
// ----------------------------------------------------------------------------
module futex_waiter_table
	import fwt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// cmd, address, expected_value, current_word, wake_count, slot_index
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status, result_value
	output logic [OUT_W-1:0] m_tdata
);

	fwt_cmd_t  ctrl;
	fwt_stat_t stat;

	fwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	fwt_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.ctrl     (ctrl),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
